/* src/goc_pkg.sv */
`timescale 1ns / 1ps

package goc_pkg;

   // Width of the reversal countdown and of the configuration register
   localparam int COUNT_WIDTH = 10;
   localparam int CFG_WIDTH   = 10;

   // Value of the reversal length register after reset
   localparam logic [CFG_WIDTH-1:0] REVERSE_TICKS_RESET = CFG_WIDTH'(17);

   // Number of sampled pins and the place of each pin in a sample
   localparam int PIN_COUNT  = 8;
   localparam int PIN_DOPEN  = 0;
   localparam int PIN_DCLOSE = 1;
   localparam int PIN_SOPEN  = 2;
   localparam int PIN_SCLOSE = 3;
   localparam int PIN_OLIM   = 4;
   localparam int PIN_CLIM   = 5;
   localparam int PIN_OBST   = 6;
   localparam int PIN_HOLD   = 7;

   // Width of a packed result item
   localparam int RSP_WIDTH = 8;

   typedef enum logic [2:0] {
      GATE_CLOSED    = 3'd0,
      GATE_OPEN      = 3'd1,
      GATE_OPENING   = 3'd2,
      GATE_CLOSING   = 3'd3,
      GATE_STOPPED   = 3'd4,
      GATE_REVERSING = 3'd5
   } gate_state_type;

   // State carried from one sample to the next
   typedef struct packed {
      logic [PIN_COUNT-1:0]   prev_pins;
      gate_state_type         gate;
      logic                   security;
      logic [COUNT_WIDTH-1:0] countdown;
   } goc_state_type;

   // Fields of one result item
   typedef struct packed {
      logic           reversal_started;
      logic           driver_refused;
      logic           security_owned;
      logic           red_led;
      logic           green_led;
      gate_state_type gate_state;
   } goc_result_type;

endpackage

/* src/goc_step.sv */
`timescale 1ns / 1ps

module goc_step (
   input  logic [goc_pkg::PIN_COUNT-1:0] pins,
   input  logic [goc_pkg::CFG_WIDTH-1:0] reverse_ticks,
   input  goc_pkg::goc_state_type        cur_state,
   output goc_pkg::goc_state_type        next_state,
   output goc_pkg::goc_result_type       result
);
   import goc_pkg::*;

   // Common width for comparing the register against the countdown range
   localparam int LOAD_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam logic [LOAD_WIDTH-1:0] COUNT_MAX = LOAD_WIDTH'((1 << COUNT_WIDTH) - 1);

   typedef struct packed {
      gate_state_type gate;
      logic           security;
   } motion_type;

   // Open command: a repeat press stops the gate unless hold-to-run is active
   function automatic motion_type open_cmd(motion_type cur, logic by_sec, logic hold);
      motion_type nxt;
      nxt = cur;
      case (cur.gate)
         GATE_OPENING: begin
            if (!hold) begin
               nxt.gate     = GATE_STOPPED;
               nxt.security = 1'b0;
            end
         end
         GATE_CLOSING: begin
            nxt.gate = GATE_OPENING;
            if (by_sec) nxt.security = 1'b1;
         end
         GATE_CLOSED, GATE_STOPPED: begin
            nxt.gate     = GATE_OPENING;
            nxt.security = by_sec;
         end
         default: begin
            nxt = cur;
         end
      endcase
      return nxt;
   endfunction

   // Close command, the mirror image of the open command
   function automatic motion_type close_cmd(motion_type cur, logic by_sec, logic hold);
      motion_type nxt;
      nxt = cur;
      case (cur.gate)
         GATE_CLOSING: begin
            if (!hold) begin
               nxt.gate     = GATE_STOPPED;
               nxt.security = 1'b0;
            end
         end
         GATE_OPENING: begin
            nxt.gate = GATE_CLOSING;
            if (by_sec) nxt.security = 1'b1;
         end
         GATE_OPEN, GATE_STOPPED: begin
            nxt.gate     = GATE_CLOSING;
            nxt.security = by_sec;
         end
         default: begin
            nxt = cur;
         end
      endcase
      return nxt;
   endfunction

   logic [PIN_COUNT-1:0]   rise;
   logic [PIN_COUNT-1:0]   fall;
   logic                   hold;
   logic                   sec_level;
   logic [LOAD_WIDTH-1:0]  load;
   motion_type             mot;
   logic [COUNT_WIDTH-1:0] cnt;
   logic                   refused;
   logic                   rev_start;

   assign rise      = pins & ~cur_state.prev_pins;
   assign fall      = ~pins & cur_state.prev_pins;
   assign hold      = pins[PIN_HOLD];
   assign sec_level = pins[PIN_SOPEN] | pins[PIN_SCLOSE];

   // Reversal length: zero acts as one, and it saturates at the countdown range
   always_comb begin
      load = LOAD_WIDTH'(reverse_ticks);
      if (load == '0) load = LOAD_WIDTH'(1);
      if (load > COUNT_MAX) load = COUNT_MAX;
   end

   // One tick in fixed order: countdown, obstacle, limits, the buttons, then the hold release
   always_comb begin
      mot.gate     = cur_state.gate;
      mot.security = cur_state.security;
      cnt          = cur_state.countdown;
      refused      = 1'b0;
      rev_start    = 1'b0;

      if (cnt != '0) begin
         cnt = cnt - COUNT_WIDTH'(1);
         if (cnt == '0) begin
            mot.gate     = GATE_STOPPED;
            mot.security = 1'b0;
         end
      end

      if (rise[PIN_OBST] && mot.gate == GATE_CLOSING && cnt == '0) begin
         mot.gate  = GATE_REVERSING;
         cnt       = load[COUNT_WIDTH-1:0];
         rev_start = 1'b1;
      end

      if (rise[PIN_OLIM] && (mot.gate == GATE_OPENING || mot.gate == GATE_REVERSING)) begin
         mot.gate     = GATE_OPEN;
         mot.security = 1'b0;
         cnt          = '0;
      end

      if (rise[PIN_CLIM] && mot.gate == GATE_CLOSING) begin
         mot.gate     = GATE_CLOSED;
         mot.security = 1'b0;
      end

      // Driver presses are refused while security holds or owns the gate
      if (rise[PIN_DOPEN]) begin
         if (sec_level || mot.security) refused = 1'b1;
         else mot = open_cmd(mot, 1'b0, hold);
      end
      if (rise[PIN_DCLOSE]) begin
         if (sec_level || mot.security) refused = 1'b1;
         else mot = close_cmd(mot, 1'b0, hold);
      end
      if (rise[PIN_SOPEN]) mot = open_cmd(mot, 1'b1, hold);
      if (rise[PIN_SCLOSE]) mot = close_cmd(mot, 1'b1, hold);

      // Releasing the hold switch stops a moving gate
      if (fall[PIN_HOLD]) begin
         if (mot.gate == GATE_OPENING || mot.gate == GATE_CLOSING) begin
            mot.gate     = GATE_STOPPED;
            mot.security = 1'b0;
         end
      end
   end

   assign next_state.prev_pins = pins;
   assign next_state.gate      = mot.gate;
   assign next_state.security  = mot.security;
   assign next_state.countdown = cnt;

   assign result.gate_state       = mot.gate;
   assign result.green_led        = (mot.gate == GATE_OPENING) || (mot.gate == GATE_REVERSING);
   assign result.red_led          = (mot.gate == GATE_CLOSING);
   assign result.security_owned   = mot.security;
   assign result.driver_refused   = refused;
   assign result.reversal_started = rev_start;

endmodule

/* src/gate_opener_controller.sv */
`timescale 1ns / 1ps

// A pin sample accepted into the sample register goes through the combinational step logic
// into the result register, which drives rsp_tdata; a result waiting on rsp_tready holds it.
// Throughput: one sample per cycle while rsp_tready is high, limited by the sample register.
// The sample register takes a new sample while an earlier result still waits, if it is empty.
// Synchronous active-high reset: gate closed, countdown idle, pin history zero,
// reversal length 17 ticks; both channels come out of reset empty.
module gate_opener_controller (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata, from bit 0: driver_open, driver_close, security_open, security_close,
   // open_limit, closed_limit, obstacle, manual_hold
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [goc_pkg::PIN_COUNT-1:0]  req_tdata,
   // rsp_tdata, from bit 0: gate_state[2:0], green_led, red_led, security_owned,
   // driver_refused, reversal_started
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [goc_pkg::RSP_WIDTH-1:0]  rsp_tdata,
   // csr_tdata: reverse_ticks
   input  logic                           csr_tvalid,
   output logic                           csr_tready,
   input  logic [goc_pkg::CFG_WIDTH-1:0]  csr_tdata
);
   import goc_pkg::*;

   logic                 smp_valid_ff;
   logic                 smp_valid_in;
   logic [PIN_COUNT-1:0] smp_pins_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   goc_result_type       rsp_data_ff;
   goc_state_type        state_ff;
   goc_state_type        state_in;
   goc_result_type       step_result;
   logic [CFG_WIDTH-1:0] ticks_ff;
   logic                 advance;

   // The sample moves on when the result register is empty or being emptied
   assign advance      = smp_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !smp_valid_ff || advance;
   assign smp_valid_in = (req_tvalid && req_tready) || (smp_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   assign csr_tready   = 1'b1;

   goc_step u_step (
      .pins          (smp_pins_ff),
      .reverse_ticks (ticks_ff),
      .cur_state     (state_ff),
      .next_state    (state_in),
      .result        (step_result)
   );

   // Control registers and the gate state
   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ticks_ff     <= REVERSE_TICKS_RESET;
         state_ff     <= '{prev_pins: '0, gate: GATE_CLOSED, security: 1'b0, countdown: '0};
      end else begin
         smp_valid_ff <= smp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_tvalid && csr_tready) ticks_ff <= csr_tdata;
         if (advance) state_ff <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) smp_pins_ff <= req_tdata;
      if (advance) rsp_data_ff <= step_result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // A running countdown and the reversing state always go together
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.countdown != '0) == (state_ff.gate == GATE_REVERSING))
      else $error("countdown and reversing state disagree");

   // Security ownership only exists while the gate is in motion
   assert property (@(posedge clock) disable iff (reset)
      state_ff.security |-> (state_ff.gate == GATE_OPENING ||
                             state_ff.gate == GATE_CLOSING ||
                             state_ff.gate == GATE_REVERSING))
      else $error("security ownership held by a gate at rest");

   // The LEDs shown in a result never light together
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.green_led && rsp_data_ff.red_led))
      else $error("green and red LEDs both lit");

   // The state only changes when a sample is processed
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("gate state changed without a sample");
`endif

endmodule
